// File: sv/ckmb_pkg.sv
// ----------------------------------------------------------------------------
// ckmb_pkg
// Shared widths, register indexes and payload types for the chroma key
// matte and blend pipeline.
// ----------------------------------------------------------------------------
package ckmb_pkg;

  // field and datapath widths
  localparam int CH_W       = 8;
  localparam int GAIN_W     = 20;
  localparam int WEIGHT_W   = 16;
  localparam int ALPHA_W    = 17;
  localparam int WB_W       = WEIGHT_W + CH_W;       // weight * blue
  localparam int DIFF_W     = WB_W + 1;              // signed Q.14 difference
  localparam int PROD_W     = GAIN_W + 1 + DIFF_W - 1 + 1; // signed Q.30 product
  localparam int MIX_W      = ALPHA_W + CH_W;        // one weighted channel
  localparam int FRAC_SHIFT = 14;                    // Q.30 down to Q1.16

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_GAIN    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_WEIGHT = 4'd1;

  localparam logic [GAIN_W-1:0]   KEY_GAIN_RST    = 20'd0;
  localparam logic [WEIGHT_W-1:0] BLUE_WEIGHT_RST = 16'd16384;

  // unity alpha in Q1.16
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

  // request acceptance to result on out_valid, in clock edges
  localparam int LATENCY = 5;

  // base and overlay pixels travelling alongside the matte
  typedef struct packed {
    logic [CH_W-1:0] base_red;
    logic [CH_W-1:0] base_green;
    logic [CH_W-1:0] base_blue;
    logic [CH_W-1:0] over_red;
    logic [CH_W-1:0] over_green;
    logic [CH_W-1:0] over_blue;
  } pix_t;

endpackage

// File: sv/ckmb_matte.sv
// ----------------------------------------------------------------------------
// ckmb_matte
// Three-stage matte pipeline: weighted difference, gain product, clamp to
// Q1.16. Pixel payload travels alongside with a valid bit per stage.
// ----------------------------------------------------------------------------
module ckmb_matte (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [ckmb_pkg::CH_W-1:0]      key_green,
  input  logic [ckmb_pkg::CH_W-1:0]      key_blue,
  input  ckmb_pkg::pix_t                 in_pix,
  input  logic [ckmb_pkg::GAIN_W-1:0]    key_gain,
  input  logic [ckmb_pkg::WEIGHT_W-1:0]  blue_weight,
  output logic                           out_valid,
  output logic [ckmb_pkg::ALPHA_W-1:0]   out_alpha,
  output ckmb_pkg::pix_t                 out_pix
);
  import ckmb_pkg::*;

  logic                     s1_valid_r, s2_valid_r, s3_valid_r;
  pix_t                     s1_pix_r, s2_pix_r, s3_pix_r;
  logic [WB_W-1:0]          wb;
  logic signed [DIFF_W-1:0] diff_nxt, diff_r;
  logic signed [GAIN_W:0]   gain_s;
  logic signed [PROD_W-1:0] prod_nxt, prod_r;
  logic [FRAC_SHIFT+ALPHA_W-1:0] rem_q30;
  logic [ALPHA_W-1:0]       alpha_nxt, alpha_r;

  // stage 1: G*2^14 - weight*B, exact signed Q.14
  assign wb       = WB_W'(blue_weight) * WB_W'(key_blue);
  assign diff_nxt = $signed({3'b000, key_green, 14'd0}) - $signed({1'b0, wb});

  // stage 2: gain times difference, exact signed Q.30
  assign gain_s   = $signed({1'b0, key_gain});
  assign prod_nxt = gain_s * diff_r;

  // stage 3: alpha = 1 - product, clamped to [0,1], floored to Q1.16
  assign rem_q30 = {1'b1, {(FRAC_SHIFT+ALPHA_W-1){1'b0}}} - {1'b0, prod_r[29:0]};

  always_comb begin
    if (prod_r[PROD_W-1] || (prod_r == '0)) begin
      alpha_nxt = ALPHA_ONE;                      // matte at or above one
    end else if (prod_r[PROD_W-2:30] != '0) begin
      alpha_nxt = '0;                             // matte at or below zero
    end else begin
      alpha_nxt = rem_q30[FRAC_SHIFT+ALPHA_W-1:FRAC_SHIFT];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    diff_r   <= diff_nxt;
    prod_r   <= prod_nxt;
    alpha_r  <= alpha_nxt;
    s1_pix_r <= in_pix;
    s2_pix_r <= s1_pix_r;
    s3_pix_r <= s2_pix_r;
  end

  assign out_valid = s3_valid_r;
  assign out_alpha = alpha_r;
  assign out_pix   = s3_pix_r;

endmodule

// File: sv/ckmb_mix.sv
// ----------------------------------------------------------------------------
// ckmb_mix
// Two-stage alpha blend: per-channel weighted products, then sum and
// truncate to 8 bits. Alpha rides along to the output register.
// ----------------------------------------------------------------------------
module ckmb_mix (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [ckmb_pkg::ALPHA_W-1:0]   in_alpha,
  input  ckmb_pkg::pix_t                 in_pix,
  output logic                           out_valid,
  output logic [ckmb_pkg::CH_W-1:0]      out_red,
  output logic [ckmb_pkg::CH_W-1:0]      out_green,
  output logic [ckmb_pkg::CH_W-1:0]      out_blue,
  output logic [ckmb_pkg::ALPHA_W-1:0]   out_alpha
);
  import ckmb_pkg::*;

  logic               p_valid_r, o_valid_r;
  logic [ALPHA_W-1:0] inv_alpha;
  logic [ALPHA_W-1:0] p_alpha_r, o_alpha_r;
  logic [MIX_W-1:0]   pb_r_nxt, pb_g_nxt, pb_b_nxt, po_r_nxt, po_g_nxt, po_b_nxt;
  logic [MIX_W-1:0]   pb_r_r, pb_g_r, pb_b_r, po_r_r, po_g_r, po_b_r;
  logic [MIX_W-1:0]   sum_r, sum_g, sum_b;
  logic [CH_W-1:0]    red_r, green_r, blue_r;

  // stage 4: (1-alpha)*base and alpha*over per channel
  assign inv_alpha = ALPHA_ONE - in_alpha;
  assign pb_r_nxt  = MIX_W'(inv_alpha) * MIX_W'(in_pix.base_red);
  assign pb_g_nxt  = MIX_W'(inv_alpha) * MIX_W'(in_pix.base_green);
  assign pb_b_nxt  = MIX_W'(inv_alpha) * MIX_W'(in_pix.base_blue);
  assign po_r_nxt  = MIX_W'(in_alpha) * MIX_W'(in_pix.over_red);
  assign po_g_nxt  = MIX_W'(in_alpha) * MIX_W'(in_pix.over_green);
  assign po_b_nxt  = MIX_W'(in_alpha) * MIX_W'(in_pix.over_blue);

  // stage 5: sum and drop 16 fraction bits; sum stays below 2^24
  assign sum_r = pb_r_r + po_r_r;
  assign sum_g = pb_g_r + po_g_r;
  assign sum_b = pb_b_r + po_b_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      p_valid_r <= in_valid;
      o_valid_r <= p_valid_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pb_r_r    <= pb_r_nxt;
    pb_g_r    <= pb_g_nxt;
    pb_b_r    <= pb_b_nxt;
    po_r_r    <= po_r_nxt;
    po_g_r    <= po_g_nxt;
    po_b_r    <= po_b_nxt;
    p_alpha_r <= in_alpha;
    red_r     <= sum_r[23:16];
    green_r   <= sum_g[23:16];
    blue_r    <= sum_b[23:16];
    o_alpha_r <= p_alpha_r;
  end

  assign out_valid = o_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;
  assign out_alpha = o_alpha_r;

endmodule

// File: sv/chroma_key_matte_blend.sv
// Pipeline: a request accepted at a clock edge passes through five register stages and
// gives its result on out_* with out_valid high for a single cycle.
// Throughput: one pixel per clock; busy stays low once out of reset.
// Reset: synchronous active-low rst_n clears all stage valid bits, sets
// key_gain to 0 and blue_weight to 1.0, and holds busy high while asserted.
// ----------------------------------------------------------------------------
// chroma_key_matte_blend
// Blue-screen matte from key green and blue, then per-channel alpha blend
// of a base pixel with an overlay pixel.
// ----------------------------------------------------------------------------
module chroma_key_matte_blend (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             start,
  output logic                             busy,
  input  logic [ckmb_pkg::CH_W-1:0]        in_key_green,
  input  logic [ckmb_pkg::CH_W-1:0]        in_key_blue,
  input  logic [ckmb_pkg::CH_W-1:0]        in_base_red,
  input  logic [ckmb_pkg::CH_W-1:0]        in_base_green,
  input  logic [ckmb_pkg::CH_W-1:0]        in_base_blue,
  input  logic [ckmb_pkg::CH_W-1:0]        in_over_red,
  input  logic [ckmb_pkg::CH_W-1:0]        in_over_green,
  input  logic [ckmb_pkg::CH_W-1:0]        in_over_blue,
  // result channel
  output logic                             out_valid,
  output logic [ckmb_pkg::CH_W-1:0]        out_red,
  output logic [ckmb_pkg::CH_W-1:0]        out_green,
  output logic [ckmb_pkg::CH_W-1:0]        out_blue,
  output logic [ckmb_pkg::ALPHA_W-1:0]     out_alpha_out,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ckmb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ckmb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ckmb_pkg::*;

  logic                busy_r;
  logic                in_acc;
  logic [GAIN_W-1:0]   key_gain_r;
  logic [WEIGHT_W-1:0] blue_weight_r;
  pix_t                in_pix;
  logic                m_valid;
  logic [ALPHA_W-1:0]  m_alpha;
  pix_t                m_pix;

  // busy only while in reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign in_acc    = start & ~busy_r;
  assign cfg_ready = 1'b1;

  // configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_gain_r    <= KEY_GAIN_RST;
      blue_weight_r <= BLUE_WEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KEY_GAIN:    key_gain_r    <= cfg_data[GAIN_W-1:0];
        REG_BLUE_WEIGHT: blue_weight_r <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_pix = '{base_red:   in_base_red,
                    base_green: in_base_green,
                    base_blue:  in_base_blue,
                    over_red:   in_over_red,
                    over_green: in_over_green,
                    over_blue:  in_over_blue};

  // matte stages
  ckmb_matte u_matte (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_acc),
    .key_green   (in_key_green),
    .key_blue    (in_key_blue),
    .in_pix      (in_pix),
    .key_gain    (key_gain_r),
    .blue_weight (blue_weight_r),
    .out_valid   (m_valid),
    .out_alpha   (m_alpha),
    .out_pix     (m_pix)
  );

  // blend stages
  ckmb_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m_valid),
    .in_alpha  (m_alpha),
    .in_pix    (m_pix),
    .out_valid (out_valid),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha_out)
  );

`ifndef SYNTHESIS
  // every accepted request comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_acc, LATENCY) |-> out_valid)
    else $error("accepted request did not produce a result");

  // matte never exceeds one
  a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_alpha_out <= ALPHA_ONE))
    else $error("alpha above one");

  // zero matte passes the base pixel straight through
  a_zero_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_alpha_out == '0) && $past(in_acc, LATENCY)) |->
      (out_red == $past(in_base_red, LATENCY)) &&
      (out_green == $past(in_base_green, LATENCY)) &&
      (out_blue == $past(in_base_blue, LATENCY)))
    else $error("zero alpha did not return the base pixel");

  // unity matte passes the overlay pixel straight through
  a_one_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_alpha_out == ALPHA_ONE) && $past(in_acc, LATENCY)) |->
      (out_red == $past(in_over_red, LATENCY)) &&
      (out_green == $past(in_over_green, LATENCY)) &&
      (out_blue == $past(in_over_blue, LATENCY)))
    else $error("unity alpha did not return the overlay pixel");
`endif

endmodule
